FILE: hw/rtl/wcr_pkg.sv
// Shared constants and types of the waveform column rasterizer.
`default_nettype none

package wcr_pkg;

    // Trace geometry and fixed-point format of a level.
    localparam int ROWS      = 11;
    localparam int FRAC      = 5;
    localparam int GLYPH_W   = 2 * ROWS;
    localparam int LEVEL_W   = 22;
    localparam int SAMPLE_W  = 16;
    localparam int GAIN_W    = 24;
    localparam int COL_W     = 8;
    localparam int IVL_W     = 20;
    localparam int PROD_W    = SAMPLE_W + GAIN_W + 1;
    localparam int POS_W     = LEVEL_W - FRAC - 1 + 2;
    localparam int TOP       = 2 * ROWS - 1;
    localparam int CLIP_W    = $clog2(TOP + 1);
    localparam int ROW_W     = CLIP_W - 1;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 24;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE   = 2'd0,
        REG_GAIN     = 2'd1,
        REG_COLUMNS  = 2'd2,
        REG_INTERVAL = 2'd3
    } cfg_reg_t;

    // Glyph codes of one cell.
    typedef enum logic [1:0] {
        CELL_BLANK = 2'd0,
        CELL_DOT   = 2'd1,
        CELL_BAR   = 2'd2,
        CELL_APOS  = 2'd3
    } cell_t;

    // Clipped vertical segment of one column, in half-row units.
    typedef struct packed {
        logic              visible;
        logic [CLIP_W-1:0] seg_start;
        logic [CLIP_W-1:0] seg_end;
    } seg_t;

    // Per-item tag carried down the pipeline.
    typedef struct packed {
        logic             emit;
        logic [COL_W-1:0] col;
        logic             done;
    } tag_t;

endpackage

`default_nettype wire

FILE: hw/rtl/waveform_column_rasterizer_core.sv
// Top level of the waveform column rasterizer: frame windowing, level pipeline, glyph packing.
`default_nettype none

// Turns a sample stream into oscilloscope glyph columns, ROWS cells high. The
// block takes one sample per clock while the output side is not stalled: a
// five-register pipeline (input register, gain multiply, level and history,
// segment extent, glyph packing) runs with per-stage valid bits, so a stage
// fills whenever the stage after it is empty or moving, and a sample passes
// through these registers in that order before its column is output.
// At the start of each frame period the first columns+2 samples are used: the
// first two only fill the level history, and each later one emits the column
// two positions back. The rest of the period is skipped; those samples
// transfer but produce nothing. With enable low, samples transfer and are
// dropped with no state change. Configuration writes are always taken
// (cfg_ready is tied high) and must only be made while the pipeline is empty.
module waveform_column_rasterizer_core
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,

    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [wcr_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [wcr_pkg::CFG_W-1:0]             cfg_data,

    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic signed [wcr_pkg::SAMPLE_W-1:0]   sample,

    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [wcr_pkg::COL_W-1:0]                  column,
    output logic [wcr_pkg::GLYPH_W-1:0]                glyphs,
    output logic                                       frame_done
);

    localparam int L = wcr_pkg::LEVEL_W;

    // Level of a zero sample: the middle of the trace.
    localparam logic signed [L-1:0] LEVEL_BASE = L'((wcr_pkg::ROWS - 1) << wcr_pkg::FRAC);

    // Configuration registers.
    logic                           enable_reg;
    logic [wcr_pkg::GAIN_W-1:0]     gain_reg;
    logic [wcr_pkg::COL_W-1:0]      columns_reg;
    logic [wcr_pkg::IVL_W-1:0]      interval_reg;

    // Frame position.
    logic [wcr_pkg::IVL_W-1:0]      frame_pos_reg;
    logic [wcr_pkg::IVL_W-1:0]      frame_pos_next;

    // Pipeline valid bits.
    logic va_reg;
    logic vb_reg;
    logic vc_reg;
    logic vd_reg;
    logic out_valid_reg;

    // Stage payloads.
    logic signed [wcr_pkg::SAMPLE_W-1:0] sample_a_reg;
    wcr_pkg::tag_t                       tag_a_reg;
    wcr_pkg::tag_t                       tag_a_next;
    logic signed [wcr_pkg::PROD_W-1:0]   prod_b_reg;
    wcr_pkg::tag_t                       tag_b_reg;
    logic signed [L-1:0]                 last_c_reg;
    logic signed [L-1:0]                 cur_c_reg;
    logic signed [L-1:0]                 next_c_reg;
    wcr_pkg::tag_t                       tag_c_reg;
    wcr_pkg::seg_t                       seg_d_reg;
    wcr_pkg::tag_t                       tag_d_reg;
    logic [wcr_pkg::COL_W-1:0]           column_reg;
    logic [wcr_pkg::GLYPH_W-1:0]         glyphs_reg;
    logic [wcr_pkg::GLYPH_W-1:0]         glyphs_next;
    logic                                frame_done_reg;

    // Level history.
    logic signed [L-1:0]                 hist_pp_reg;
    logic signed [L-1:0]                 hist_p_reg;

    // Handshake and stage moves.
    logic adv_a;
    logic adv_b;
    logic adv_c;
    logic adv_d;
    logic adv_e;
    logic in_xfer;
    logic cfg_xfer;
    logic store;

    logic [wcr_pkg::COL_W:0]             span;
    logic [wcr_pkg::IVL_W:0]             pos_inc;
    logic signed [wcr_pkg::GAIN_W:0]     gain_s;
    logic signed [L-1:0]                 level_b;
    wcr_pkg::seg_t                       seg_c;

    // A stage loads when it is empty or its content moves on.
    assign adv_e = !out_valid_reg || out_ready;
    assign adv_d = !vd_reg || adv_e;
    assign adv_c = !vc_reg || adv_d;
    assign adv_b = !vb_reg || adv_c;
    assign adv_a = !va_reg || adv_b;

    assign in_ready  = adv_a;
    assign in_xfer   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= 1'b0;
            gain_reg     <= '0;
            columns_reg  <= wcr_pkg::COL_W'(80);
            interval_reg <= wcr_pkg::IVL_W'(4000);
        end
        else if (cfg_xfer)
        begin
            unique case (wcr_pkg::cfg_reg_t'(cfg_index))
                wcr_pkg::REG_ENABLE:   enable_reg   <= cfg_data[0];
                wcr_pkg::REG_GAIN:     gain_reg     <= cfg_data[wcr_pkg::GAIN_W-1:0];
                wcr_pkg::REG_COLUMNS:  columns_reg  <= cfg_data[wcr_pkg::COL_W-1:0];
                wcr_pkg::REG_INTERVAL: interval_reg <= cfg_data[wcr_pkg::IVL_W-1:0];
                default:               enable_reg   <= enable_reg;
            endcase
        end
    end

    // Frame window: the column count is 8 bits wide. Positions below columns+2
    // store a sample; beyond that, advance and wrap once the period is reached.
    assign span    = {1'b0, columns_reg} + (wcr_pkg::COL_W+1)'(2);
    assign store   = frame_pos_reg < wcr_pkg::IVL_W'(span);
    assign pos_inc = {1'b0, frame_pos_reg} + (wcr_pkg::IVL_W+1)'(1);

    always_comb
    begin
        frame_pos_next  = frame_pos_reg;
        tag_a_next.emit = frame_pos_reg >= wcr_pkg::IVL_W'(2);
        tag_a_next.col  = wcr_pkg::COL_W'(frame_pos_reg - wcr_pkg::IVL_W'(2));
        tag_a_next.done = (frame_pos_reg[wcr_pkg::COL_W:0] - (wcr_pkg::COL_W+1)'(1))
                          == {1'b0, columns_reg};
        if (in_xfer && enable_reg)
        begin
            if (store)
            begin
                frame_pos_next = pos_inc[wcr_pkg::IVL_W-1:0];
            end
            else if (pos_inc >= {1'b0, interval_reg})
            begin
                frame_pos_next = '0;
            end
            else
            begin
                frame_pos_next = pos_inc[wcr_pkg::IVL_W-1:0];
            end
        end
    end

    // Level from the product: middle level minus floor(sample * gain / 2^19).
    assign gain_s  = signed'({1'b0, gain_reg});
    assign level_b = LEVEL_BASE - L'(prod_b_reg >>> (wcr_pkg::GAIN_W - wcr_pkg::FRAC));

    wcr_segment u_segment
    (
        .lvl_last (last_c_reg),
        .lvl_cur  (cur_c_reg),
        .lvl_next (next_c_reg),
        .seg      (seg_c)
    );

    // Pack the segment into cell glyphs: ends get a dot, bar or apostrophe
    // by their half-row parity, rows strictly between get a bar.
    always_comb
    begin
        wcr_pkg::cell_t      cell_v;
        logic [wcr_pkg::ROW_W-1:0] s_row;
        logic [wcr_pkg::ROW_W-1:0] e_row;
        logic                same_end;
        s_row       = seg_d_reg.seg_start[wcr_pkg::CLIP_W-1:1];
        e_row       = seg_d_reg.seg_end[wcr_pkg::CLIP_W-1:1];
        same_end    = seg_d_reg.seg_start == seg_d_reg.seg_end;
        glyphs_next = '0;
        for (int k = 0; k < wcr_pkg::ROWS; k++)
        begin
            cell_v = wcr_pkg::CELL_BLANK;
            if (seg_d_reg.visible)
            begin
                if ((wcr_pkg::ROW_W'(k) > s_row) && (wcr_pkg::ROW_W'(k) < e_row))
                begin
                    cell_v = wcr_pkg::CELL_BAR;
                end
                if (wcr_pkg::ROW_W'(k) == s_row)
                begin
                    if (seg_d_reg.seg_start[0])
                    begin
                        cell_v = wcr_pkg::CELL_DOT;
                    end
                    else if (!same_end)
                    begin
                        cell_v = wcr_pkg::CELL_BAR;
                    end
                end
                if (wcr_pkg::ROW_W'(k) == e_row)
                begin
                    if (!seg_d_reg.seg_end[0])
                    begin
                        cell_v = wcr_pkg::CELL_APOS;
                    end
                    else if (!same_end)
                    begin
                        cell_v = wcr_pkg::CELL_BAR;
                    end
                end
            end
            glyphs_next[2*k +: 2] = cell_v;
        end
    end

    // Control state: valid bits, frame position and level history.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_pos_reg <= '0;
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
            vc_reg        <= 1'b0;
            vd_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            hist_pp_reg   <= '0;
            hist_p_reg    <= '0;
        end
        else
        begin
            frame_pos_reg <= frame_pos_next;
            if (adv_a)
            begin
                va_reg <= in_xfer && enable_reg && store;
            end
            if (adv_b)
            begin
                vb_reg <= va_reg;
            end
            if (adv_c)
            begin
                vc_reg <= vb_reg;
                // Shift the history as each stored level enters the draw stage.
                if (vb_reg)
                begin
                    hist_pp_reg <= hist_p_reg;
                    hist_p_reg  <= level_b;
                end
            end
            if (adv_d)
            begin
                // Drop items that only fill the history.
                vd_reg <= vc_reg && tag_c_reg.emit;
            end
            if (adv_e)
            begin
                out_valid_reg <= vd_reg;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (adv_a)
        begin
            sample_a_reg <= sample;
            tag_a_reg    <= tag_a_next;
        end
        if (adv_b)
        begin
            prod_b_reg <= sample_a_reg * gain_s;
            tag_b_reg  <= tag_a_reg;
        end
        if (adv_c)
        begin
            last_c_reg <= hist_pp_reg;
            cur_c_reg  <= hist_p_reg;
            next_c_reg <= level_b;
            tag_c_reg  <= tag_b_reg;
        end
        if (adv_d)
        begin
            seg_d_reg <= seg_c;
            tag_d_reg <= tag_c_reg;
        end
        if (adv_e)
        begin
            column_reg     <= tag_d_reg.col;
            glyphs_reg     <= glyphs_next;
            frame_done_reg <= tag_d_reg.done;
        end
    end

    assign out_valid  = out_valid_reg;
    assign column     = column_reg;
    assign glyphs     = glyphs_reg;
    assign frame_done = frame_done_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/wcr_segment.sv
// Segment extent of one column from three neighboring levels, clipped to the rows.
`default_nettype none

module wcr_segment
(
    input  wire logic signed [wcr_pkg::LEVEL_W-1:0] lvl_last,
    input  wire logic signed [wcr_pkg::LEVEL_W-1:0] lvl_cur,
    input  wire logic signed [wcr_pkg::LEVEL_W-1:0] lvl_next,
    output wcr_pkg::seg_t                           seg
);

    localparam int L = wcr_pkg::LEVEL_W;
    localparam int P = wcr_pkg::POS_W;
    localparam int C = wcr_pkg::CLIP_W;
    localparam logic signed [P-1:0] TOP_S = P'(wcr_pkg::TOP);

    function automatic logic signed [P-1:0] floor_half(input logic signed [L:0] x);
        floor_half = P'(x >>> (wcr_pkg::FRAC + 1));
    endfunction

    function automatic logic signed [P-1:0] ceil_half(input logic signed [L:0] x);
        logic signed [L+1:0] t;
        t = {x[L], x} + (L+2)'((1 << (wcr_pkg::FRAC + 1)) - 1);
        ceil_half = P'(t >>> (wcr_pkg::FRAC + 1));
    endfunction

    logic signed [L:0]   sum_l;
    logic signed [L:0]   sum_n;
    logic signed [L:0]   cur_x;
    logic        [L:0]   mag;
    logic        [L:0]   mag_r;
    logic signed [P-1:0] rpos;
    logic signed [P-1:0] rnd;
    logic signed [P-1:0] s;
    logic signed [P-1:0] e;

    assign sum_l = {lvl_last[L-1], lvl_last} + {lvl_cur[L-1], lvl_cur};
    assign sum_n = {lvl_next[L-1], lvl_next} + {lvl_cur[L-1], lvl_cur};

    // Round the current level to nearest, halves away from zero.
    assign cur_x = {lvl_cur[L-1], lvl_cur};
    assign mag   = cur_x[L] ? (L+1)'(-cur_x) : (L+1)'(cur_x);
    assign mag_r = (mag + (L+1)'(1 << (wcr_pkg::FRAC - 1))) >> wcr_pkg::FRAC;
    assign rpos  = signed'(P'(mag_r));
    assign rnd   = cur_x[L] ? -rpos : rpos;

    always_comb
    begin
        s = rnd;
        e = rnd;
        if (lvl_last > lvl_cur)
        begin
            if (lvl_next > lvl_cur)
            begin
                // Valley: from the rounded level to the midpoint with the farther neighbor.
                s = rnd;
                e = (lvl_last > lvl_next) ? floor_half(sum_l) : floor_half(sum_n);
                if (e < s)
                begin
                    e = s;
                end
            end
            else
            begin
                s = ceil_half(sum_n);
                e = floor_half(sum_l);
                if (e < s)
                begin
                    s = rnd;
                    e = rnd;
                end
            end
        end
        else
        begin
            if (lvl_next <= lvl_cur)
            begin
                // Peak: from the midpoint with the farther neighbor to the rounded level.
                e = rnd;
                s = (lvl_last <= lvl_next) ? ceil_half(sum_l) : ceil_half(sum_n);
                if (s > e)
                begin
                    s = e;
                end
            end
            else
            begin
                s = ceil_half(sum_l);
                e = floor_half(sum_n);
                if (s > e)
                begin
                    s = rnd;
                    e = rnd;
                end
            end
        end
    end

    always_comb
    begin
        seg.visible   = !e[P-1] && (s < TOP_S);
        seg.seg_start = s[P-1] ? '0 : s[C-1:0];
        seg.seg_end   = (e >= TOP_S) ? C'(wcr_pkg::TOP) : e[C-1:0];
    end

endmodule

`default_nettype wire
